FILE: rtl/tmwe_pkg.sv
// Shared constants, codes and controller/datapath interface types
// for the tile map wall edge extractor. No dependencies.
package tmwe_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int MAX_EDGES  = 1024;

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int IDW  = $clog2(MAX_EDGES);
    localparam int CNTW = IDW + 1;
    localparam int DIMW = 7;
    localparam int TSW  = 8;
    localparam int CW   = 14;
    localparam int CIDW = 2 * (IDW + 1);

    localparam logic [1:0] FUNC_WRITE   = 2'd0;
    localparam logic [1:0] FUNC_EXTRACT = 2'd1;
    localparam logic [1:0] FUNC_READ    = 2'd2;

    localparam logic [1:0] CFG_ROOM_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_ROOM_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_TILE_SIZE   = 2'd2;

    typedef enum logic [3:0] {
        OP_IDLE, OP_LOAD, OP_MAP_WR, OP_SCAN_INIT, OP_LOAD_CUR, OP_FETCH,
        OP_LATCH_NEXT, OP_CELL, OP_SIDE, OP_ADVANCE, OP_READ_LATCH, OP_FINISH
    } t_op;

    typedef enum logic [1:0] {SIDE_W, SIDE_E, SIDE_N, SIDE_S} t_side;

    typedef struct packed {
        t_op   op;
        t_side side;
    } t_cmd;

    typedef struct packed {
        logic scan_empty;
        logic last_x;
        logic last_y;
        logic out_busy;
    } t_status;

endpackage

FILE: rtl/tmwe_ram.sv
// Generic single write port RAM with one registered read port.
// No dependencies.
module tmwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/tmwe_ctrl.sv
// Sequencer for tile writes, the edge extraction scan and edge reads.
// Depends on tmwe_pkg.
module tmwe_ctrl import tmwe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_func,
    input  t_status    i_status,
    output logic       o_stall,
    output t_cmd       o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_WR, S_SC_INIT, S_LOAD0, S_FETCH, S_NEXT, S_CELL, S_SIDE,
        S_ADV, S_RD, S_FIN
    } t_state;

    t_state r_state, n_state;
    t_side  r_side, n_side;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_side     = r_side;
        o_cmd.op   = OP_IDLE;
        o_cmd.side = r_side;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    priority case (i_func)
                        FUNC_WRITE:   n_state = S_WR;
                        FUNC_EXTRACT: n_state = S_SC_INIT;
                        FUNC_READ:    n_state = S_RD;
                        default:      n_state = S_FIN;
                    endcase
                end
            end
            S_WR: begin
                o_cmd.op = OP_MAP_WR;
                n_state  = S_FIN;
            end
            S_SC_INIT: begin
                o_cmd.op = OP_SCAN_INIT;
                n_state  = i_status.scan_empty ? S_FIN : S_LOAD0;
            end
            S_LOAD0: begin
                o_cmd.op = OP_LOAD_CUR;
                n_state  = S_NEXT;
            end
            S_FETCH: begin
                o_cmd.op = OP_FETCH;
                n_state  = S_NEXT;
            end
            S_NEXT: begin
                o_cmd.op = OP_LATCH_NEXT;
                n_state  = S_CELL;
            end
            S_CELL: begin
                o_cmd.op = OP_CELL;
                n_side   = SIDE_W;
                n_state  = S_SIDE;
            end
            S_SIDE: begin
                o_cmd.op = OP_SIDE;
                if (r_side != SIDE_S) begin
                    n_side = t_side'(r_side + 2'd1);
                end else if (!i_status.last_y) begin
                    n_state = S_CELL;
                end else if (!i_status.last_x) begin
                    n_state = S_ADV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_ADV: begin
                o_cmd.op = OP_ADVANCE;
                n_state  = S_FETCH;
            end
            S_RD: begin
                o_cmd.op = OP_READ_LATCH;
                n_state  = S_FIN;
            end
            S_FIN: begin
                if (!i_status.out_busy) begin
                    o_cmd.op = OP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_side  <= SIDE_W;
        end else begin
            r_state <= n_state;
            r_side  <= n_side;
        end
    end
endmodule

FILE: rtl/tmwe_dp.sv
// Datapath: configuration, wall map, scan columns, edge id bookkeeping,
// edge tables and the result register. Depends on tmwe_pkg, tmwe_ram.
module tmwe_dp import tmwe_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cmd            i_cmd,
    output t_status         o_status,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [TSW-1:0]  i_cfg_data,
    input  logic [XW-1:0]   i_tile_x,
    input  logic [YW-1:0]   i_tile_y,
    input  logic            i_is_wall,
    input  logic [IDW-1:0]  i_edge_index,
    input  logic            i_stall,
    output logic            o_valid,
    output logic [CNTW-1:0] o_edge_count,
    output logic            o_overflow,
    output logic            o_edge_valid,
    output logic [CW-1:0]   o_start_x,
    output logic [CW-1:0]   o_start_y,
    output logic [CW-1:0]   o_end_x,
    output logic [CW-1:0]   o_end_y
);
    logic [DIMW-1:0] r_room_width, r_room_height, w_sat, h_sat;
    logic [TSW-1:0]  r_tile_size;
    logic [CW-1:0]   ts;

    logic [XW-1:0]   r_tile_x;
    logic [YW-1:0]   r_tile_y;
    logic            r_is_wall;
    logic [IDW-1:0]  r_ei;

    logic [MAX_HEIGHT-1:0] map_rdata, map_wdata, r_prev, r_cur, r_next;
    logic [XW-1:0]   map_raddr;
    logic [XW-1:0]   r_x;
    logic [YW-1:0]   r_y;
    logic [CW-1:0]   r_px, r_py, r_px1, r_py1;
    logic            r_f_wall, r_f_above, r_f_below, r_f_left, r_f_right;
    logic [1:0]      r_ab_v;
    logic [IDW-1:0]  r_ab_id [2];
    logic            r_nn_v;
    logic [IDW-1:0]  r_nn_id;
    logic [CNTW-1:0] r_count;
    logic            r_ovf;

    logic [CIDW-1:0] col_rdata, col_wdata;
    logic            col_we;

    logic [2*CW-1:0] st_rdata, en_rdata, st_wdata, en_wdata;
    logic            st_we, en_we;

    logic            need, cont, pv, do_cont, do_new, full, id_v;
    logic [IDW-1:0]  pid, id;
    logic [CW-1:0]   sx, sy, ex, ey;

    logic            r_rd_valid;
    logic [CW-1:0]   r_rd_sx, r_rd_sy, r_rd_ex, r_rd_ey;

    assign w_sat = (r_room_width > DIMW'(MAX_WIDTH)) ? DIMW'(MAX_WIDTH) : r_room_width;
    assign h_sat = (r_room_height > DIMW'(MAX_HEIGHT)) ? DIMW'(MAX_HEIGHT) : r_room_height;
    assign ts    = CW'(r_tile_size);

    assign o_status.scan_empty = (w_sat == '0) || (h_sat == '0);
    assign o_status.last_x     = (DIMW'(r_x) + DIMW'(1)) >= w_sat;
    assign o_status.last_y     = (DIMW'(r_y) + DIMW'(1)) >= h_sat;
    assign o_status.out_busy   = o_valid && i_stall;

    always_comb begin
        unique case (i_cmd.op)
            OP_LOAD:      map_raddr = i_tile_x;
            OP_SCAN_INIT: map_raddr = '0;
            default:      map_raddr = r_x + XW'(1);
        endcase
        map_wdata = map_rdata;
        map_wdata[r_tile_y] = r_is_wall;
    end

    tmwe_ram #(.WIDTH(MAX_HEIGHT), .DEPTH(MAX_WIDTH)) u_map (
        .i_clk   (i_clk),
        .i_we    (i_cmd.op == OP_MAP_WR),
        .i_waddr (r_tile_x),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    tmwe_ram #(.WIDTH(CIDW), .DEPTH(MAX_HEIGHT)) u_col_ids (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (r_y),
        .i_wdata (col_wdata),
        .i_raddr (r_y),
        .o_rdata (col_rdata)
    );

    tmwe_ram #(.WIDTH(2 * CW), .DEPTH(MAX_EDGES)) u_edge_start (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (id),
        .i_wdata (st_wdata),
        .i_raddr (i_edge_index),
        .o_rdata (st_rdata)
    );

    tmwe_ram #(.WIDTH(2 * CW), .DEPTH(MAX_EDGES)) u_edge_end (
        .i_clk   (i_clk),
        .i_we    (en_we),
        .i_waddr (id),
        .i_wdata (en_wdata),
        .i_raddr (i_edge_index),
        .o_rdata (en_rdata)
    );

    // one side of the current wall cell
    always_comb begin
        need = 1'b0;
        cont = 1'b0;
        pv   = 1'b0;
        pid  = '0;
        sx   = r_px;
        sy   = r_py;
        ex   = r_px1;
        ey   = r_py1;
        unique case (i_cmd.side)
            SIDE_W: begin
                need = r_f_wall && !r_f_left;
                cont = r_f_above;
                pv   = r_ab_v[0];
                pid  = r_ab_id[0];
                ex   = r_px;
            end
            SIDE_E: begin
                need = r_f_wall && !r_f_right;
                cont = r_f_above;
                pv   = r_ab_v[1];
                pid  = r_ab_id[1];
                sx   = r_px1;
            end
            SIDE_N: begin
                need = r_f_wall && !r_f_above;
                cont = r_f_left;
                pv   = col_rdata[CIDW-1];
                pid  = col_rdata[CIDW-2 -: IDW];
                ey   = r_py;
            end
            SIDE_S: begin
                need = r_f_wall && !r_f_below;
                cont = r_f_left;
                pv   = col_rdata[IDW];
                pid  = col_rdata[IDW-1:0];
                sy   = r_py1;
            end
            default: ;
        endcase
        full     = r_count >= CNTW'(MAX_EDGES);
        do_cont  = need && cont && pv;
        do_new   = need && !do_cont && !full;
        id_v     = do_cont || do_new;
        id       = do_cont ? pid : r_count[IDW-1:0];
        st_wdata = {sx, sy};
        en_wdata = {ex, ey};
        st_we    = (i_cmd.op == OP_SIDE) && do_new;
        en_we    = (i_cmd.op == OP_SIDE) && id_v;
        col_we   = (i_cmd.op == OP_SIDE) && (i_cmd.side == SIDE_S);
        col_wdata = {r_nn_v, r_nn_id, id_v, id};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_room_width  <= DIMW'(16);
            r_room_height <= DIMW'(16);
            r_tile_size   <= TSW'(16);
            r_count       <= '0;
            r_ovf         <= 1'b0;
            r_ab_v        <= '0;
            o_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                priority case (i_cfg_index)
                    CFG_ROOM_WIDTH:  r_room_width  <= i_cfg_data[DIMW-1:0];
                    CFG_ROOM_HEIGHT: r_room_height <= i_cfg_data[DIMW-1:0];
                    CFG_TILE_SIZE:   r_tile_size   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_FINISH) begin
                o_valid <= 1'b1;
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_SCAN_INIT: begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                    r_ab_v  <= '0;
                end
                OP_SIDE: begin
                    if (need && !do_cont && full) begin
                        r_ovf <= 1'b1;
                    end
                    if (do_new) begin
                        r_count <= r_count + CNTW'(1);
                    end
                    if (i_cmd.side == SIDE_W) begin
                        r_ab_v[0] <= id_v;
                    end
                    if (i_cmd.side == SIDE_E) begin
                        r_ab_v[1] <= id_v;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_tile_x   <= i_tile_x;
                r_tile_y   <= i_tile_y;
                r_is_wall  <= i_is_wall;
                r_ei       <= i_edge_index;
                r_rd_valid <= 1'b0;
                r_rd_sx    <= '0;
                r_rd_sy    <= '0;
                r_rd_ex    <= '0;
                r_rd_ey    <= '0;
            end
            OP_SCAN_INIT: begin
                r_x  <= '0;
                r_y  <= '0;
                r_px <= '0;
                r_py <= '0;
            end
            OP_LOAD_CUR: begin
                r_cur  <= map_rdata;
                r_prev <= '0;
            end
            OP_LATCH_NEXT: begin
                r_next <= o_status.last_x ? '0 : map_rdata;
            end
            OP_CELL: begin
                r_f_wall  <= r_cur[r_y];
                r_f_above <= (r_y != '0) && r_cur[r_y - YW'(1)];
                r_f_below <= ((DIMW'(r_y) + DIMW'(1)) < h_sat) && r_cur[r_y + YW'(1)];
                r_f_left  <= r_prev[r_y];
                r_f_right <= r_next[r_y];
                r_px1     <= r_px + ts;
                r_py1     <= r_py + ts;
            end
            OP_SIDE: begin
                unique case (i_cmd.side)
                    SIDE_W: r_ab_id[0] <= id;
                    SIDE_E: r_ab_id[1] <= id;
                    SIDE_N: begin
                        r_nn_v  <= id_v;
                        r_nn_id <= id;
                    end
                    SIDE_S: begin
                        r_y  <= r_y + YW'(1);
                        r_py <= r_py1;
                    end
                    default: ;
                endcase
            end
            OP_ADVANCE: begin
                r_prev <= r_cur;
                r_cur  <= r_next;
                r_x    <= r_x + XW'(1);
                r_px   <= r_px + ts;
                r_y    <= '0;
                r_py   <= '0;
            end
            OP_READ_LATCH: begin
                if (CNTW'(r_ei) < r_count) begin
                    r_rd_valid <= 1'b1;
                    {r_rd_sx, r_rd_sy} <= st_rdata;
                    {r_rd_ex, r_rd_ey} <= en_rdata;
                end
            end
            OP_FINISH: begin
                o_edge_count <= r_count;
                o_overflow   <= r_ovf;
                o_edge_valid <= r_rd_valid;
                o_start_x    <= r_rd_sx;
                o_start_y    <= r_rd_sy;
                o_end_x      <= r_rd_ex;
                o_end_y      <= r_rd_ey;
            end
            default: ;
        endcase
    end
endmodule

FILE: rtl/tile_map_wall_edge_extractor.sv
// Tile map wall edge extractor top level: controller plus datapath.
// Depends on tmwe_pkg, tmwe_ctrl, tmwe_dp.
//
// One item at a time. A tile write and an edge read each pass through one
// working state and then the finish state, which registers the result; the
// block is free for the next item once the result is presented. An edge
// read does one registered table read. An extraction of a room whose width
// or height is zero goes from scan init straight to the finish state. For
// each column the scan advances, then fetches and latches the next wall map
// column; the first column loads the current column and latches the next.
// Each cell is set up, then its sides are handled one by one, since every
// side may write the edge tables through their single write port. Any item
// also waits in its finish state while the previous result is held by i_stall.
// Edge count and overflow come back with every item.
module tile_map_wall_edge_extractor import tmwe_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [TSW-1:0]  i_cfg_data,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [1:0]      i_func,
    input  logic [XW-1:0]   i_tile_x,
    input  logic [YW-1:0]   i_tile_y,
    input  logic            i_is_wall,
    input  logic [IDW-1:0]  i_edge_index,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [CNTW-1:0] o_edge_count,
    output logic            o_overflow,
    output logic            o_edge_valid,
    output logic [CW-1:0]   o_start_x,
    output logic [CW-1:0]   o_start_y,
    output logic [CW-1:0]   o_end_x,
    output logic [CW-1:0]   o_end_y
);
    t_cmd    cmd;
    t_status status;

    tmwe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_func   (i_func),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    tmwe_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_tile_x     (i_tile_x),
        .i_tile_y     (i_tile_y),
        .i_is_wall    (i_is_wall),
        .i_edge_index (i_edge_index),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_edge_count (o_edge_count),
        .o_overflow   (o_overflow),
        .o_edge_valid (o_edge_valid),
        .o_start_x    (o_start_x),
        .o_start_y    (o_start_y),
        .o_end_x      (o_end_x),
        .o_end_y      (o_end_y)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken again right after an item");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_edge_count <= CNTW'(MAX_EDGES)))
        else $error("edge count beyond table size");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_edge_count == CNTW'(MAX_EDGES)))
        else $error("overflow with table not full");
endmodule

FILE: tb/testbench.sv
// Self-checking testbench for tile_map_wall_edge_extractor: random tile writes,
// edge extractions and edge reads checked against an in-bench predictor.
// Depends on tmwe_pkg and the RTL of the block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tmwe_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int NONE = -1;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct {
        logic [1:0]     func;
        logic [XW-1:0]  tx;
        logic [YW-1:0]  ty;
        logic           wall;
        logic [IDW-1:0] idx;
    } t_item;

    typedef struct {
        logic [CNTW-1:0] count;
        logic            ovf;
        logic            ev;
        logic [CW-1:0]   sx, sy, ex, ey;
    } t_result;

    logic i_clk = 0, i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [1:0] i_cfg_index = '0;
    logic [TSW-1:0] i_cfg_data = '0;
    logic i_valid = 0, i_stall = 0, o_stall, o_valid;
    logic [1:0] i_func = '0;
    logic [XW-1:0] i_tile_x = '0;
    logic [YW-1:0] i_tile_y = '0;
    logic i_is_wall = 0;
    logic [IDW-1:0] i_edge_index = '0;
    logic [CNTW-1:0] o_edge_count;
    logic o_overflow, o_edge_valid;
    logic [CW-1:0] o_start_x, o_start_y, o_end_x, o_end_y;

    tile_map_wall_edge_extractor DUT (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // predictor state
    bit wall_map [MAX_HEIGHT][MAX_WIDTH];
    int col_ids [MAX_HEIGHT][2];
    int above_ids [2];
    int edge_sx [MAX_EDGES], edge_sy [MAX_EDGES], edge_ex [MAX_EDGES], edge_ey [MAX_EDGES];
    int edges_found = 0;
    bit overflow_flag = 0;
    int room_w = 16, room_h = 16, tile_sz = 16;

    // generation-side knowledge
    bit written [MAX_HEIGHT][MAX_WIDTH];
    int gen_w = 16, gen_h = 16;
    int gap_max = 9;

    t_item pending_items[$];
    t_result expected_results[$];
    int errors = 0, items_sent = 0, results_seen = 0;
    int extractions = 0, overflow_seen = 0, valid_reads = 0;

    function automatic bit map_at(int x, int y);
        if (x >= MAX_WIDTH || y >= MAX_HEIGHT) return 0;
        return wall_map[y][x];
    endfunction

    function automatic int extend_or_open(int prev, bit cont, int sx, int sy, int ex, int ey);
        int id;
        if (cont && prev != NONE && prev < MAX_EDGES) begin
            edge_ex[prev] = ex;
            edge_ey[prev] = ey;
            return prev;
        end
        if (edges_found >= MAX_EDGES) begin
            overflow_flag = 1;
            return NONE;
        end
        id = edges_found++;
        edge_sx[id] = sx; edge_sy[id] = sy; edge_ex[id] = ex; edge_ey[id] = ey;
        return id;
    endfunction

    function automatic void extract_edges();
        int w, h, px, py, idw, ide, idn, ids;
        bit up, lf, rt, dn;
        w = room_w > MAX_WIDTH ? MAX_WIDTH : room_w;
        h = room_h > MAX_HEIGHT ? MAX_HEIGHT : room_h;
        edges_found = 0;
        overflow_flag = 0;
        above_ids[0] = NONE;
        above_ids[1] = NONE;
        for (int x = 0; x < w; x++) begin
            for (int y = 0; y < h; y++) begin
                idw = NONE; ide = NONE; idn = NONE; ids = NONE;
                px = x * tile_sz;
                py = y * tile_sz;
                if (map_at(x, y)) begin
                    up = y > 0 && map_at(x, y - 1);
                    lf = x > 0 && map_at(x - 1, y);
                    rt = x + 1 < w && map_at(x + 1, y);
                    dn = y + 1 < h && map_at(x, y + 1);
                    if (!lf) idw = extend_or_open(above_ids[0], up, px, py, px, py + tile_sz);
                    if (!rt) ide = extend_or_open(above_ids[1], up, px + tile_sz, py,
                                                  px + tile_sz, py + tile_sz);
                    if (!up) idn = extend_or_open(col_ids[y][0], lf, px, py, px + tile_sz, py);
                    if (!dn) ids = extend_or_open(col_ids[y][1], lf, px, py + tile_sz,
                                                  px + tile_sz, py + tile_sz);
                end
                above_ids[0] = idw;
                above_ids[1] = ide;
                col_ids[y][0] = idn;
                col_ids[y][1] = ids;
            end
        end
    endfunction

    function automatic t_result predict_item(t_item it);
        t_result r;
        r = '{default: '0};
        case (it.func)
            FUNC_WRITE: wall_map[it.ty][it.tx] = it.wall;
            FUNC_EXTRACT: extract_edges();
            FUNC_READ: if (it.idx < edges_found) begin
                r.ev = 1;
                r.sx = edge_sx[it.idx][CW-1:0];
                r.sy = edge_sy[it.idx][CW-1:0];
                r.ex = edge_ex[it.idx][CW-1:0];
                r.ey = edge_ey[it.idx][CW-1:0];
            end
            default: ;
        endcase
        r.count = edges_found[CNTW-1:0];
        r.ovf = overflow_flag;
        return r;
    endfunction

    // driver
    int send_gap = 0;
    always @(posedge i_clk) begin
        t_item it;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                it = '{i_func, i_tile_x, i_tile_y, i_is_wall, i_edge_index};
                expected_results.push_back(predict_item(it));
                items_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0 || pending_items.size() == 0) begin
                    if (send_gap > 0) send_gap--;
                    i_valid <= 0;
                end else begin
                    it = pending_items.pop_front();
                    i_func <= it.func;
                    i_tile_x <= it.tx;
                    i_tile_y <= it.ty;
                    i_is_wall <= it.wall;
                    i_edge_index <= it.idx;
                    i_valid <= 1;
                    send_gap = $urandom_range(0, gap_max);
                end
            end
        end
    end

    // monitor
    int stall_left = 0;
    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result item");
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    check_field("edge_count", e.count, o_edge_count);
                    check_field("overflow", e.ovf, o_overflow);
                    check_field("edge_valid", e.ev, o_edge_valid);
                    check_field("start_x", e.sx, o_start_x);
                    check_field("start_y", e.sy, o_start_y);
                    check_field("end_x", e.ex, o_end_x);
                    check_field("end_y", e.ey, o_end_y);
                    if (e.ovf && o_overflow) overflow_seen++;
                    if (e.ev) valid_reads++;
                end
                stall_left = $urandom_range(0, gap_max);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_stall <= stall_left > 0;
        end
    end

    // watchdog
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
            (pending_items.size() == 0 && expected_results.size() == 0 && !i_valid))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout");
            $display("testbench failed");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic push_item(logic [1:0] f, int x, int y, bit w, int idx);
        t_item it;
        it = '{f, x[XW-1:0], y[YW-1:0], w, idx[IDW-1:0]};
        if (f == FUNC_WRITE) written[y][x] = 1;
        if (f == FUNC_EXTRACT) extractions++;
        pending_items.push_back(it);
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || i_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(int w, int h, int ts);
        drain();
        @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_index <= CFG_ROOM_WIDTH; i_cfg_data <= w[TSW-1:0];
        @(posedge i_clk);
        i_cfg_index <= CFG_ROOM_HEIGHT; i_cfg_data <= h[TSW-1:0];
        @(posedge i_clk);
        i_cfg_index <= CFG_TILE_SIZE; i_cfg_data <= ts[TSW-1:0];
        @(posedge i_clk);
        i_cfg_we <= 0;
        room_w = w; room_h = h; tile_sz = ts;
        gen_w = w > MAX_WIDTH ? MAX_WIDTH : w;
        gen_h = h > MAX_HEIGHT ? MAX_HEIGHT : h;
        gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
    endtask

    // mode 0 random walls, 1 checkerboard
    task automatic fill_room(int mode);
        for (int x = 0; x < gen_w; x++)
            for (int y = 0; y < gen_h; y++)
                if (!written[y][x] || mode == 1)
                    push_item(FUNC_WRITE, x, y,
                              mode == 1 ? ((x + y) % 2 == 0) : ($urandom_range(0, 9) < 6), 0);
    endtask

    task automatic random_items(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                if ($urandom_range(0, 4) == 0 || gen_w == 0 || gen_h == 0)
                    push_item(FUNC_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                              $urandom_range(0, 1), $urandom_range(0, 1023));
                else
                    push_item(FUNC_WRITE, $urandom_range(0, gen_w - 1),
                              $urandom_range(0, gen_h - 1), $urandom_range(0, 9) < 6,
                              $urandom_range(0, 1023));
            end else if (r < 55)
                push_item(FUNC_EXTRACT, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 1), $urandom_range(0, 1023));
            else if (r < 95)
                push_item(FUNC_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 1),
                          $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
                                                    : $urandom_range(0, 60));
            else
                push_item(FUNC_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 1), $urandom_range(0, 1023));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: small room, every func, read extremes, unused index
        configure(3, 2, 255);
        fill_room(0);
        push_item(FUNC_WRITE, 63, 63, 1, 1023);
        push_item(FUNC_READ, 0, 0, 0, 0);
        push_item(FUNC_EXTRACT, 0, 0, 0, 0);
        for (int i = 0; i < 6; i++) push_item(FUNC_READ, 0, 0, 0, i);
        push_item(FUNC_READ, 63, 63, 1, 1023);
        push_item(FUNC_UNUSED, 63, 63, 1, 1023);
        drain();
        @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_index <= CFG_UNUSED; i_cfg_data <= 8'hFF;
        @(posedge i_clk);
        i_cfg_we <= 0;

        // empty rooms
        configure(0, 5, 16);
        push_item(FUNC_EXTRACT, 0, 0, 0, 0);
        push_item(FUNC_READ, 0, 0, 0, 0);
        configure(5, 0, 1);
        fill_room(0);
        push_item(FUNC_EXTRACT, 0, 0, 0, 0);
        push_item(FUNC_READ, 0, 0, 0, 0);

        // saturated width, checkerboard overruns the edge table
        configure(127, 10, 255);
        fill_room(1);
        push_item(FUNC_EXTRACT, 0, 0, 0, 0);
        push_item(FUNC_READ, 0, 0, 0, 1023);
        push_item(FUNC_READ, 0, 0, 0, 0);
        random_items(60);

        configure(1, 127, 200);
        fill_room(0);
        push_item(FUNC_EXTRACT, 0, 0, 0, 0);
        random_items(40);

        configure(64, 1, 0);
        fill_room(0);
        push_item(FUNC_EXTRACT, 0, 0, 0, 0);
        random_items(30);

        while (items_sent + pending_items.size() < 1700) begin
            configure($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(0, 255));
            fill_room(0);
            push_item(FUNC_EXTRACT, 0, 0, 0, 0);
            random_items(100);
        end
        drain();
        repeat (20) @(posedge i_clk);

        $display("%0d items sent, %0d results checked, %0d extractions", items_sent,
                 results_seen, extractions);
        $display("%0d valid edge reads, %0d results with overflow set", valid_reads,
                 overflow_seen);
        if (errors == 0 && expected_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
